>>> design/glyph_1bpp_to_4bpp_packer_top_assert.svh
// ----------------------------------------------------------------------------
// glyph_1bpp_to_4bpp_packer_top_assert.svh
// Assertion macros for the glyph packer. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef GLYPH_1BPP_TO_4BPP_PACKER_TOP_ASSERT_SVH
`define GLYPH_1BPP_TO_4BPP_PACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define GPK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpk assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define GPK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpk assertion failed");
`else
`define GPK_ASSERT_NOW(label, ante, cons)
`define GPK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/gpk_pkg.sv
// ----------------------------------------------------------------------------
// gpk_pkg
// Types, constants and the nibble step function shared by the glyph packer.
// ----------------------------------------------------------------------------
package gpk_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_GLYPH_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_GLYPH_HEIGHT = 1'd1;

  // Pixel nibble codes
  localparam logic [3:0] NIB_ON  = 4'hF;
  localparam logic [3:0] NIB_OFF = 4'h0;

  // Pixels per input beat
  localparam logic [3:0] PIX_PER_BYTE = 4'd8;

  // One accepted bitmap byte, classified by the front end
  typedef struct packed {
    logic [7:0] bits;    // bitmap byte, MSB first
    logic [3:0] npix;    // pixels of this byte that belong to the glyph (1..8)
    logic       fin;     // this byte holds the glyph's last pixel
  } item_t;

  // Control from the front end to the back end
  typedef struct packed {
    logic       clear;   // a register write clears all state
    logic [7:0] width;   // glyph width in pixels
  } ctl_t;

  // One result beat
  typedef struct packed {
    logic [7:0] gram_byte;
    logic       run_last;
    logic       glyph_last;
  } result_t;

  // Back-end working state
  typedef struct packed {
    logic [3:0] idx;       // next bit of the current item
    logic       pad_due;   // a pad nibble closes the row just ended
    logic [7:0] col;       // pixels consumed in the current row
    logic [3:0] pend_nib;  // high nibble waiting for its partner
    logic       pend_v;
  } back_st_t;

  typedef struct packed {
    back_st_t   st;
    logic       gram_v;
    logic [7:0] gram;
  } step_res_t;

  // Advance by one nibble: a pending pad, else the next pixel, else nothing.
  function automatic step_res_t nib_step(back_st_t s, logic [7:0] bits,
                                         logic [3:0] npix, logic [7:0] width);
    step_res_t  r;
    logic [3:0] nib;
    logic [7:0] col_inc;
    logic       active;
    r        = '0;
    r.st     = s;
    nib      = NIB_OFF;
    col_inc  = s.col + 8'd1;
    active   = 1'b0;
    if (s.pad_due) begin
      nib          = NIB_OFF;
      r.st.pad_due = 1'b0;
      active       = 1'b1;
    end else if (s.idx < npix) begin
      nib      = bits[~s.idx[2:0]] ? NIB_ON : NIB_OFF;
      r.st.idx = s.idx + 4'd1;
      if (col_inc == width) begin
        r.st.col     = '0;
        r.st.pad_due = width[0];
      end else begin
        r.st.col = col_inc;
      end
      active = 1'b1;
    end
    if (active) begin
      if (s.pend_v) begin
        r.gram_v      = 1'b1;
        r.gram        = {s.pend_nib, nib};
        r.st.pend_v   = 1'b0;
        r.st.pend_nib = NIB_OFF;
      end else begin
        r.st.pend_nib = nib;
        r.st.pend_v   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> design/gpk_fifo.sv
// ----------------------------------------------------------------------------
// gpk_fifo
// Small register queue with flush; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module gpk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    if (flush) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/gpk_front.sv
// ----------------------------------------------------------------------------
// gpk_front
// Holds the glyph size, counts pixels and classifies each accepted byte.
// ----------------------------------------------------------------------------
module gpk_front
  import gpk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_accept,
  input  logic [7:0]         in_bitmap_byte,
  output logic               item_push,
  output item_t              item,
  output ctl_t               ctl
);

  logic [7:0]  width_r, width_nxt;
  logic [7:0]  height_r, height_nxt;
  logic [15:0] pix_cnt_r, pix_cnt_nxt;
  logic        done_r, done_nxt;
  logic [15:0] total;
  logic [15:0] remain;
  logic        reg_hit;
  logic        last_byte;

  assign total     = {8'd0, width_r} * {8'd0, height_r};
  assign remain    = total - pix_cnt_r;
  assign last_byte = (remain <= 16'(PIX_PER_BYTE));
  assign reg_hit   = cfg_we && (cfg_index == REG_GLYPH_WIDTH ||
                                cfg_index == REG_GLYPH_HEIGHT);

  // Classify the beat: drop it once the glyph is complete or when it has no pixels
  always_comb begin
    item_push = in_accept && !done_r && (total != '0);
    item.bits = in_bitmap_byte;
    item.npix = last_byte ? remain[3:0] : PIX_PER_BYTE;
    item.fin  = last_byte;
  end

  assign ctl.clear = reg_hit;
  assign ctl.width = width_r;

  // Update registers and pixel count
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    pix_cnt_nxt = pix_cnt_r;
    done_nxt    = done_r;
    if (reg_hit) begin
      if (cfg_index == REG_GLYPH_WIDTH) begin
        width_nxt = cfg_data;
      end else begin
        height_nxt = cfg_data;
      end
      pix_cnt_nxt = '0;
      done_nxt    = 1'b0;
    end else if (item_push) begin
      pix_cnt_nxt = pix_cnt_r + 16'(item.npix);
      done_nxt    = last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 8'd1;
      height_r  <= 8'd1;
      pix_cnt_r <= '0;
      done_r    <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

>>> design/gpk_back.sv
// ----------------------------------------------------------------------------
// gpk_back
// Expands queued bytes into nibbles, two per cycle while the result queue has room, and emits display bytes.
// ----------------------------------------------------------------------------
module gpk_back
  import gpk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ctl_t    ctl,
  input  logic    item_empty,
  input  item_t   item,
  output logic    item_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  back_st_t   st_r, st_nxt;
  step_res_t  s1, s2;
  logic       go;
  logic       done_after;
  logic       rem_one;
  logic       tail_pad;
  logic       last_res;

  // Two nibble steps per cycle; two nibbles always close exactly one byte
  assign go = !item_empty && !res_full;
  assign s1 = nib_step(st_r, item.bits, item.npix, ctl.width);
  assign s2 = nib_step(s1.st, item.bits, item.npix, ctl.width);

  // Look ahead: is this the item's final byte?
  assign done_after = !s2.st.pad_due && (s2.st.idx == item.npix);
  assign tail_pad   = ((s2.st.col + 8'd1) == ctl.width) && ctl.width[0];
  assign rem_one    = (s2.st.pad_due && (s2.st.idx == item.npix)) ||
                      (!s2.st.pad_due && ((s2.st.idx + 4'd1) == item.npix) && !tail_pad);
  assign last_res   = done_after || (rem_one && !s2.st.pend_v);

  always_comb begin
    res_push       = go && (s1.gram_v || s2.gram_v);
    res.gram_byte  = s1.gram_v ? s1.gram : s2.gram;
    res.run_last   = last_res;
    res.glyph_last = last_res && item.fin;
    item_pop       = go && done_after;
  end

  // Advance state; drop the item once all its nibbles are out
  always_comb begin
    st_nxt = st_r;
    if (ctl.clear) begin
      st_nxt = '0;
    end else if (go) begin
      st_nxt = s2.st;
      if (done_after) begin
        st_nxt.idx = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> design/glyph_1bpp_to_4bpp_packer_top.sv
// ----------------------------------------------------------------------------
// glyph_1bpp_to_4bpp_packer_top
// Expands a 1-bit glyph bitmap into 4-bit grayscale display RAM bytes.
// ----------------------------------------------------------------------------
// Write glyph_width (index 0) and glyph_height (index 1) while idle; any
// write restarts the glyph. Bitmap bytes go in MSB first through push/full,
// display bytes come out through empty/pop, first pixel in the high nibble,
// with run_last on the final byte caused by an input beat and glyph_last on
// the glyph's final byte. The back end turns two pixel or pad nibbles into
// one output byte per cycle while a beat is queued and the result queue
// has room: a full input byte of an even-width glyph yields 4 output bytes,
// up to 8 when every pixel ends an odd-width row, fewer on the glyph's final
// beat. Bytes after the glyph is complete are accepted and dropped. An input
// beat is registered in the item queue, its results in the result queue.
`include "glyph_1bpp_to_4bpp_packer_top_assert.svh"

module glyph_1bpp_to_4bpp_packer_top
  import gpk_pkg::*;
#(
  parameter int ITEM_DEPTH = 2,
  parameter int RES_DEPTH  = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_bitmap_byte,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_gram_byte,
  output logic               out_run_last,
  output logic               out_glyph_last
);

  ctl_t    ctl;
  item_t   item_in, item_head;
  logic    item_push, item_pop, item_full, item_empty;
  result_t res_in, res_head;
  logic    res_push, res_full;
  logic [$bits(item_t)-1:0]   item_vec;
  logic [$bits(result_t)-1:0] res_vec;

  assign full = item_full;

  // Accept and classify input beats
  gpk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_accept      (push && !item_full),
    .in_bitmap_byte (in_bitmap_byte),
    .item_push      (item_push),
    .item           (item_in),
    .ctl            (ctl)
  );

  // Decouple front and back
  gpk_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (ctl.clear),
    .push      (item_push),
    .push_data (item_in),
    .full      (item_full),
    .pop       (item_pop),
    .pop_data  (item_vec),
    .empty     (item_empty)
  );

  assign item_head = item_t'(item_vec);

  // Expand nibbles into display bytes
  gpk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item_empty (item_empty),
    .item       (item_head),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  // Hold results until taken
  gpk_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (ctl.clear),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_vec),
    .empty     (empty)
  );

  assign res_head       = result_t'(res_vec);
  assign out_gram_byte  = res_head.gram_byte;
  assign out_run_last   = res_head.run_last;
  assign out_glyph_last = res_head.glyph_last;

  // Checks
  `GPK_ASSERT_NOW(a_res_no_overflow, res_push, !res_full)
  `GPK_ASSERT_NOW(a_glyph_last_ends_run, !empty && out_glyph_last, out_run_last)
  `GPK_ASSERT_NEXT(a_clear_flushes, ctl.clear, item_empty && empty)
  `GPK_ASSERT_NOW(a_pop_needs_item, item_pop, !item_empty)

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1bpp to 4bpp glyph packer. It writes glyph
// sizes, streams bitmap bytes with random gaps and result stalls, predicts
// every display RAM byte and checks each beat against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gpk_pkg::*;

  // Predicts display bytes from bitmap bytes and checks them in order
  class gram_scoreboard;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [3:0]  half_nib;
    logic        half_valid;
    logic [15:0] pix_done;
    logic [7:0]  col_done;
    logic        glyph_done;
    result_t     gram_due[$];
    int          errors;
    int          checked;

    function new();
      width   = 8'd1;
      height  = 8'd1;
      errors  = 0;
      checked = 0;
      restart_glyph();
    endfunction

    function void restart_glyph();
      half_nib   = NIB_OFF;
      half_valid = 1'b0;
      pix_done   = '0;
      col_done   = '0;
      glyph_done = 1'b0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx == REG_GLYPH_WIDTH) begin
        width = val;
      end else if (idx == REG_GLYPH_HEIGHT) begin
        height = val;
      end
      restart_glyph();
    endfunction

    // Pair a nibble with the waiting one; return 1 when a byte completes
    function bit pair_nibble(logic [3:0] nib, output logic [7:0] gram);
      gram = '0;
      if (half_valid) begin
        gram       = {half_nib, nib};
        half_valid = 1'b0;
        half_nib   = NIB_OFF;
        return 1'b1;
      end
      half_nib   = nib;
      half_valid = 1'b1;
      return 1'b0;
    endfunction

    // Expand one accepted bitmap byte; return the number of display bytes due
    function int note_bitmap_byte(logic [7:0] bits);
      logic [15:0] total;
      result_t     beats [8];
      logic [7:0]  gram;
      int          n;
      total = {8'd0, width} * {8'd0, height};
      n     = 0;
      if (glyph_done || total == 16'd0) return 0;
      for (int i = 0; i < 8 && !glyph_done; i++) begin
        if (pair_nibble(bits[7-i] ? NIB_ON : NIB_OFF, gram)) begin
          beats[n] = '{gram_byte: gram, run_last: 1'b0, glyph_last: 1'b0};
          n++;
        end
        pix_done = pix_done + 16'd1;
        col_done = col_done + 8'd1;
        // close the row, padding odd widths with a dark nibble
        if (col_done >= width) begin
          col_done = '0;
          if (width[0] && pair_nibble(NIB_OFF, gram)) begin
            beats[n] = '{gram_byte: gram, run_last: 1'b0, glyph_last: 1'b0};
            n++;
          end
        end
        if (pix_done >= total) glyph_done = 1'b1;
      end
      if (n > 0) begin
        beats[n-1].run_last   = 1'b1;
        beats[n-1].glyph_last = glyph_done;
      end
      for (int k = 0; k < n; k++) gram_due.push_back(beats[k]);
      return n;
    endfunction

    function void log_failure(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_gram_beat(result_t got);
      result_t want;
      checked++;
      if (gram_due.size() == 0) begin
        log_failure($sformatf("unexpected beat: byte %02h run_last %0b glyph_last %0b",
                              got.gram_byte, got.run_last, got.glyph_last));
        return;
      end
      want = gram_due.pop_front();
      if (got.gram_byte !== want.gram_byte || got.run_last !== want.run_last ||
          got.glyph_last !== want.glyph_last) begin
        log_failure($sformatf(
          "beat %0d: expected byte %02h run_last %0b glyph_last %0b, got %02h %0b %0b",
          checked, want.gram_byte, want.run_last, want.glyph_last,
          got.gram_byte, got.run_last, got.glyph_last));
      end
    endfunction

    function void close_out();
      if (gram_due.size() != 0)
        log_failure($sformatf("%0d display bytes never arrived", gram_due.size()));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_data;
  logic               push;
  logic               full;
  logic [7:0]         in_bitmap_byte;
  logic               empty;
  logic               pop;
  logic [7:0]         out_gram_byte;
  logic               out_run_last;
  logic               out_glyph_last;

  gram_scoreboard sb;
  bit             no_gaps;
  int             bytes_sent;
  int             bytes_dropped;
  int             setups;
  int             stall_left;
  int             free_run;

  glyph_1bpp_to_4bpp_packer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_bitmap_byte (in_bitmap_byte),
    .empty          (empty),
    .pop            (pop),
    .out_gram_byte  (out_gram_byte),
    .out_run_last   (out_run_last),
    .out_glyph_last (out_glyph_last)
  );

  always #5 clk = ~clk;

  // Check each popped beat, then decide whether to stall the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      pop        <= 1'b0;
      stall_left = 0;
      free_run   = 0;
    end else begin
      if (pop && !empty)
        sb.check_gram_beat(result_t'({out_gram_byte, out_run_last, out_glyph_last}));
      if (free_run > 0) begin
        free_run--;
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        case ($urandom_range(0, 99)) inside
          [0:14]:  stall_left = $urandom_range(1, 3);
          [15:18]: stall_left = $urandom_range(10, 40);
          [19:22]: free_run = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(1, 12));
    if (r < 85) return 8'($urandom_range(13, 255));
    if (r < 92) return 8'd255;
    return 8'd1;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Write the chosen registers back to back, in random order when both
  task automatic configure(input bit set_w, input logic [7:0] w,
                           input bit set_h, input logic [7:0] h);
    bit w_first;
    w_first = $urandom_range(0, 1);
    if (set_h && !w_first) begin
      cfg_we <= 1'b1; cfg_index <= REG_GLYPH_HEIGHT; cfg_data <= h;
      @(posedge clk);
      sb.write_register(REG_GLYPH_HEIGHT, h);
    end
    if (set_w) begin
      cfg_we <= 1'b1; cfg_index <= REG_GLYPH_WIDTH; cfg_data <= w;
      @(posedge clk);
      sb.write_register(REG_GLYPH_WIDTH, w);
    end
    if (set_h && w_first) begin
      cfg_we <= 1'b1; cfg_index <= REG_GLYPH_HEIGHT; cfg_data <= h;
      @(posedge clk);
      sb.write_register(REG_GLYPH_HEIGHT, h);
    end
    cfg_we <= 1'b0;
    setups++;
  endtask

  // Push one bitmap beat; push stays high afterwards for a back-to-back beat
  task automatic send_byte(input logic [7:0] b, output int n);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_bitmap_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    n = sb.note_bitmap_byte(b);
    bytes_sent++;
    if (n == 0) bytes_dropped++;
  endtask

  // Drop push, wait for every due byte, then let dropped beats drain
  task automatic settle();
    push <= 1'b0;
    while (sb.gram_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int n;
    int need;
    int count;
    int r;
    logic [7:0] w;
    logic [7:0] h;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_GLYPH_WIDTH;
    cfg_data       = '0;
    push           = 1'b0;
    in_bitmap_byte = '0;
    no_gaps        = 1'b0;
    bytes_sent     = 0;
    bytes_dropped  = 0;
    setups         = 0;
    sb             = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size is one pixel; the second beat comes after the glyph is done
    send_byte(8'h80, n);
    send_byte(8'h7F, n);
    settle();
    // largest glyph, left unfinished
    configure(1'b1, 8'd255, 1'b1, 8'd255);
    send_byte(8'hFF, n);
    send_byte(8'h00, n);
    send_byte(8'hAA, n);
    send_byte(8'h55, n);
    settle();
    // odd width pads every row; surplus bits of the last beat are dropped
    configure(1'b1, 8'd3, 1'b1, 8'd3);
    send_byte(8'hB6, n);
    send_byte(8'hFF, n);
    send_byte(8'h12, n);
    settle();
    // even width, no padding
    configure(1'b1, 8'd8, 1'b1, 8'd2);
    send_byte(8'hFF, n);
    send_byte(8'h01, n);
    send_byte(8'h80, n);
    settle();
    // one-pixel rows: every pixel ends a row, eight bytes per beat
    configure(1'b1, 8'd1, 1'b1, 8'd255);
    send_byte(8'hFF, n);
    send_byte(8'h5A, n);
    settle();
    // empty glyphs ignore every beat
    configure(1'b1, 8'd0, 1'b0, 8'd0);
    send_byte(8'hFF, n);
    send_byte(8'h33, n);
    settle();
    configure(1'b1, 8'd4, 1'b1, 8'd0);
    send_byte(8'h0F, n);
    settle();

    // random glyph sizes, mostly complete glyphs with a few surplus beats
    while (bytes_sent < 260) begin
      r = $urandom_range(0, 99);
      w = pick_dim();
      h = pick_dim();
      if (r < 60) configure(1'b1, w, 1'b1, h);
      else if (r < 80) configure(1'b1, w, 1'b0, h);
      else configure(1'b0, w, 1'b1, h);
      need = (int'(sb.width) * int'(sb.height) + 7) / 8;
      if (need > 40) count = $urandom_range(4, 40);
      else if ($urandom_range(0, 99) < 15) count = $urandom_range(1, need);
      else count = need + $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < count; k++) begin
        send_byte(pick_byte(), n);
      end
      settle();
    end

    sb.close_out();
    $display("Covered %0d glyph setups and %0d bitmap beats (%0d dropped).",
             setups, bytes_sent, bytes_dropped);
    $display("Checked %0d display bytes, %0d failures.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
